### rtl/core/mctm_pkg.sv
// Shared types, constants and codes for the motor current trimmed-mean monitor.
package mctm_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;
  localparam int MAX_WINDOW  = 256;

  localparam int CH_W    = $clog2(CHANNELS);
  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int REG_W   = 13;
  localparam int ADDR_W  = 2;
  localparam int MASK_W  = 4;
  localparam int IDX_W   = 2;
  localparam int CODE_W  = 2;
  localparam int PROD_W  = SAMPLE_BITS + REG_W;

  localparam int IN_RAW_W = CHANNELS * SAMPLE_BITS + MASK_W;
  localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_W    = 32;

  // Groups beyond this count use the trimmed form
  localparam int TRIM_MIN_COUNT = 2;

  localparam logic [REG_W-1:0] THRESHOLD_RESET = REG_W'(100);
  localparam logic [REG_W-1:0] VREF_RESET      = REG_W'(3300);

  // Configuration register indexes
  localparam logic [ADDR_W-1:0] REG_THRESHOLD = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] REG_VREF      = ADDR_W'(1);

  // Result status and fault codes
  localparam logic [CODE_W-1:0] ST_STOPPED = CODE_W'(0);
  localparam logic [CODE_W-1:0] ST_RUNNING = CODE_W'(1);
  localparam logic [CODE_W-1:0] ST_FAULT   = CODE_W'(2);

  localparam logic [CODE_W-1:0] FLT_NONE  = CODE_W'(0);
  localparam logic [CODE_W-1:0] FLT_UNDER = CODE_W'(1);
  localparam logic [CODE_W-1:0] FLT_OVER  = CODE_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_EVAL
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            acc;
    logic            load;
    logic            step;
    logic            mul;
    logic            emit;
    logic            clear;
    logic [CH_W-1:0] ch;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/mctm_ctrl.sv
// Sequencer for window accumulation and per-motor result evaluation.
module mctm_ctrl import mctm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t            state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last_ch;

  assign last_ch = (ch_r == CH_W'(CHANNELS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tlast) state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (step_r == STEP_W'(SUM_W - 1)) state_nxt = S_MUL;
      end
      S_MUL: state_nxt = S_EVAL;
      S_EVAL: begin
        if (stat.out_free) state_nxt = last_ch ? S_IDLE : S_LOAD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    cmd.ch    = ch_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.acc   = in_tvalid;
      end
      S_LOAD: cmd.load = 1'b1;
      S_DIV:  cmd.step = 1'b1;
      S_MUL:  cmd.mul  = 1'b1;
      S_EVAL: begin
        cmd.emit  = stat.out_free;
        cmd.clear = stat.out_free && last_ch;
      end
      default: ;
    endcase
  end

  // Channel and divider step counters
  always_comb begin
    ch_nxt   = ch_r;
    step_nxt = step_r;
    if (state_r == S_IDLE) ch_nxt = '0;
    if (state_r == S_EVAL && stat.out_free) ch_nxt = ch_r + CH_W'(1);
    if (state_r == S_LOAD) step_nxt = '0;
    if (state_r == S_DIV)  step_nxt = step_r + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### rtl/core/mctm_dp.sv
// Accumulators, shared divider, scaling multiplier and output register.
module mctm_dp import mctm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ADDR_W-1:0]  cfg_addr,
  input  logic [REG_W-1:0]   cfg_wdata,
  input  logic [IN_W-1:0]    in_tdata,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,
  output logic               out_tlast
);

  logic [REG_W-1:0]       thr_r, vref_r;
  logic [SUM_W-1:0]       sum_r [CHANNELS];
  logic [SAMPLE_BITS-1:0] min_r [CHANNELS];
  logic [SAMPLE_BITS-1:0] max_r [CHANNELS];
  logic [CNT_W-1:0]       cnt_r;
  logic                   ovf_r;
  logic [MASK_W-1:0]      run_r;

  logic [SUM_W-1:0]       quo_r;
  logic [CNT_W-1:0]       rem_r;
  logic [CNT_W-1:0]       div_r;
  logic [PROD_W-1:0]      prod_r;

  logic                   ovalid_r;
  logic [OUT_W-1:0]       odata_r;
  logic                   olast_r;

  logic [SAMPLE_BITS-1:0] smp [CHANNELS];
  logic [CNT_W:0]         trial;
  logic                   fits;
  logic                   trim;
  logic [REG_W-1:0]       ma;
  logic                   is_run, has_cur;
  logic [CODE_W-1:0]      st_code, flt_code;

  // Unpack the sample word
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      smp[c] = in_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RESET;
      vref_r <= VREF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_THRESHOLD: thr_r  <= cfg_wdata;
        REG_VREF:      vref_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Window accumulators: one add and compare per lane per word
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_r[c] <= '0;
        min_r[c] <= '1;
        max_r[c] <= '0;
      end
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.acc) begin
      if (cnt_r < CNT_W'(MAX_WINDOW)) begin
        for (int c = 0; c < CHANNELS; c++) begin
          sum_r[c] <= sum_r[c] + SUM_W'(smp[c]);
          if (smp[c] < min_r[c]) min_r[c] <= smp[c];
          if (smp[c] > max_r[c]) max_r[c] <= smp[c];
        end
        cnt_r <= cnt_r + CNT_W'(1);
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Hold the running mask of the latest word
  always_ff @(posedge clk) begin
    if (cmd.acc) run_r <= in_tdata[CHANNELS*SAMPLE_BITS +: MASK_W];
  end

  // Restoring divider, one quotient bit per cycle
  assign trim  = (cnt_r > CNT_W'(TRIM_MIN_COUNT));
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
      if (trim) begin
        quo_r <= sum_r[cmd.ch] - SUM_W'(min_r[cmd.ch]) - SUM_W'(max_r[cmd.ch]);
        div_r <= cnt_r - CNT_W'(TRIM_MIN_COUNT);
      end else begin
        quo_r <= sum_r[cmd.ch];
        div_r <= cnt_r;
      end
    end else if (cmd.step) begin
      rem_r <= fits ? CNT_W'(trial - {1'b0, div_r}) : CNT_W'(trial);
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  // Scale the mean, trimmed or plain, by the reference
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= PROD_W'(quo_r[SAMPLE_BITS-1:0]) * PROD_W'(vref_r);
  end

  // Classify the motor
  assign ma      = prod_r[SAMPLE_BITS +: REG_W];
  assign is_run  = run_r[cmd.ch];
  assign has_cur = (ma > thr_r);

  always_comb begin
    if (is_run == has_cur) begin
      st_code  = is_run ? ST_RUNNING : ST_STOPPED;
      flt_code = FLT_NONE;
    end else begin
      st_code  = ST_FAULT;
      flt_code = has_cur ? FLT_OVER : FLT_UNDER;
    end
  end

  // Output register
  assign stat.out_free = !ovalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      odata_r <= {ovf_r, flt_code, st_code, ma, quo_r[SAMPLE_BITS-1:0], IDX_W'(cmd.ch)};
      olast_r <= (cmd.ch == CH_W'(CHANNELS - 1));
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

endmodule

### rtl/core/motor_current_trimmed_mean_monitor.sv
// Top level of the motor current trimmed-mean monitor.
// Each accepted word is one ADC group of four motor current samples; words
// are taken one per cycle while a window is open. The word with tlast closes
// the window: it is accumulated, input is then held off, and four result words
// follow, one per motor, the fourth with tlast. Each motor in turn is loaded,
// divided on the shared restoring divider, which yields one quotient bit per
// cycle, scaled and evaluated; output back-pressure holds the evaluate step.
// Input is accepted again once the last result is registered.
// Groups past MAX_WINDOW are dropped and reported as window_too_long.
module motor_current_trimmed_mean_monitor import mctm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]  cfg_wdata,
  // sample groups
  input  logic              in_tvalid,
  output logic              in_tready,
  // sample_motor1..4 (12 each), running_mask (4), zero pad (4)
  input  logic [IN_W-1:0]   in_tdata,
  input  logic              in_tlast,
  // results
  output logic              out_tvalid,
  input  logic              out_tready,
  // motor_index (2), filtered_adc (12), scaled current in mA (13), status (2),
  // fault kind (2), window_too_long (1)
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mctm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mctm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Closing word stops intake until the results are out
  a_close_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after window close");

  // The final motor's word carries tlast, and only it
  a_last_is_final_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == IDX_W'(CHANNELS - 1))))
    else $error("tlast not on final motor");

  // Fault status and fault code agree
  a_fault_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[28:27] == ST_FAULT) == (out_tdata[30:29] != FLT_NONE)))
    else $error("status and fault code disagree");

  // No results while a window is still open
  a_no_result_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result without window close");

endmodule

### dv/tb_motor_current_trimmed_mean_monitor.sv
// Self-checking testbench for the motor current trimmed-mean monitor.
`timescale 1ns / 100ps

module tb_motor_current_trimmed_mean_monitor import mctm_pkg::*; ();

  // Cycles to close one window, plus margin
  localparam int DRAIN_CYCLES   = CHANNELS * (SUM_W + 3) + 16;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASES         = 6;
  localparam int ITEMS_PER_PHASE = 6;

  // Register indexes that decode to nothing
  localparam logic [ADDR_W-1:0] REG_SPARE0 = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] REG_SPARE1 = ADDR_W'(3);

  // One ADC group as it travels on the input channel
  typedef struct packed {
    logic [MASK_W-1:0]                       running;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0]    sample;
    logic                                    last;
  } adc_group_t;

  // Result word, lowest field in the lowest bits
  typedef struct packed {
    logic                   too_long;
    logic [CODE_W-1:0]      fault;
    logic [CODE_W-1:0]      status;
    logic [REG_W-1:0]       milliamps;
    logic [SAMPLE_BITS-1:0] filtered;
    logic [IDX_W-1:0]       motor;
  } motor_report_t;

  typedef struct packed {
    logic          last;
    motor_report_t w;
  } report_due_t;

  // Directed row: a group and, where obvious, the report for every motor
  typedef struct packed {
    adc_group_t             grp;
    logic                   typed;
    logic [SAMPLE_BITS-1:0] filtered;
    logic [REG_W-1:0]       milliamps;
    logic [CODE_W-1:0]      status;
    logic [CODE_W-1:0]      fault;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [ADDR_W-1:0]   cfg_addr;
  logic [REG_W-1:0]    cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tlast;

  // Predictor copy of configuration and window accumulators
  logic [REG_W-1:0]    pred_threshold;
  logic [REG_W-1:0]    pred_vref;
  int unsigned         win_sum [CHANNELS];
  int unsigned         win_min [CHANNELS];
  int unsigned         win_max [CHANNELS];
  int unsigned         win_groups;
  logic                win_dropped;

  report_due_t         motor_reports_due[$];
  directed_row_t       directed_rows[$];
  int unsigned         mismatches;
  int unsigned         cycle_count = 0;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  hold_epoch;
  int                  hold_seen = 0;
  int                  hold_left = 0;

  motor_current_trimmed_mean_monitor u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receive side: check each accepted word, then pick the next ready value
  always @(posedge clk) begin
    report_due_t   due;
    motor_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = motor_report_t'(out_tdata);
      if (motor_reports_due.size() == 0) begin
        $display("%0t: unexpected word expected none actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        due = motor_reports_due.pop_front();
        check_field("motor_index", due.w.motor, got.motor);
        check_field("filtered_adc", due.w.filtered, got.filtered);
        check_field("milliamps", due.w.milliamps, got.milliamps);
        check_field("status", due.w.status, got.status);
        check_field("fault_kind", due.w.fault, got.fault);
        check_field("window_too_long", due.w.too_long, got.too_long);
        check_field("last_of_run", due.last, out_tlast);
      end
    end
    if (hold_epoch != hold_seen) begin
      hold_seen  <= hold_epoch;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic clear_window();
    for (int c = 0; c < CHANNELS; c++) begin
      win_sum[c] = 0;
      win_min[c] = (1 << SAMPLE_BITS) - 1;
      win_max[c] = 0;
    end
    win_groups  = 0;
    win_dropped = 1'b0;
  endtask

  // Accumulate one group; on a window end queue the four motor reports
  task automatic accumulate_window(input adc_group_t g);
    report_due_t r;
    int unsigned mean;
    int unsigned ma;
    logic        drawing;
    if (win_groups < MAX_WINDOW) begin
      for (int c = 0; c < CHANNELS; c++) begin
        win_sum[c] += g.sample[c];
        if (g.sample[c] < win_min[c]) win_min[c] = g.sample[c];
        if (g.sample[c] > win_max[c]) win_max[c] = g.sample[c];
      end
      win_groups++;
    end else begin
      win_dropped = 1'b1;
    end
    if (g.last) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (win_groups > TRIM_MIN_COUNT)
          mean = (win_sum[c] - win_min[c] - win_max[c]) / (win_groups - 2);
        else if (win_groups == 0)
          mean = 0;
        else
          mean = win_sum[c] / win_groups;
        r.w.motor      = IDX_W'(c);
        r.w.filtered   = SAMPLE_BITS'(mean);
        ma             = (int'(r.w.filtered) * int'(pred_vref)) >> SAMPLE_BITS;
        r.w.milliamps  = REG_W'(ma);
        drawing        = (r.w.milliamps > pred_threshold);
        if (g.running[c] == drawing) begin
          r.w.status = drawing ? ST_RUNNING : ST_STOPPED;
          r.w.fault  = FLT_NONE;
        end else begin
          r.w.status = ST_FAULT;
          r.w.fault  = drawing ? FLT_OVER : FLT_UNDER;
        end
        r.w.too_long = win_dropped;
        r.last       = (c == CHANNELS - 1);
        motor_reports_due.push_back(r);
      end
      clear_window();
    end
  endtask

  // Offer one word, idling first at the current rate
  task automatic offer_group(input adc_group_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({g.running, g.sample});
    in_tlast  <= g.last;
    do @(posedge clk); while (!in_tready);
    accumulate_window(g);
  endtask

  task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_THRESHOLD: pred_threshold = data;
      REG_VREF:      pred_vref      = data;
      default: ;
    endcase
  endtask

  // Hold input until every report is back and the block has settled
  task automatic wait_reports_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (motor_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_window(input int unsigned len);
    adc_group_t g;
    for (int unsigned i = 0; i < len; i++) begin
      for (int c = 0; c < CHANNELS; c++) g.sample[c] = random_sample();
      g.running = MASK_W'($urandom);
      g.last    = (i == len - 1);
      offer_group(g);
    end
  endtask

  function automatic directed_row_t mk_row(
      input logic [SAMPLE_BITS-1:0] s1, s2, s3, s4,
      input logic [MASK_W-1:0] running, input logic last, input logic typed,
      input logic [SAMPLE_BITS-1:0] filtered, input logic [REG_W-1:0] ma,
      input logic [CODE_W-1:0] status, input logic [CODE_W-1:0] fault);
    directed_row_t r;
    r.grp.sample  = {s4, s3, s2, s1};
    r.grp.running = running;
    r.grp.last    = last;
    r.typed       = typed;
    r.filtered    = filtered;
    r.milliamps   = ma;
    r.status      = status;
    r.fault       = fault;
    return r;
  endfunction

  initial begin
    report_due_t r;
    int unsigned n;
    int unsigned phase_items;
    int unsigned len;
    logic [REG_W-1:0] thr;
    logic [REG_W-1:0] vref;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_addr      <= '0;
    cfg_wdata     <= '0;
    in_tvalid     <= 1'b0;
    in_tdata      <= '0;
    in_tlast      <= 1'b0;
    send_idle_pct <= 33;
    recv_idle_pct <= 81;
    hold_epoch    <= 0;
    mismatches     = 0;
    pred_threshold = THRESHOLD_RESET;
    pred_vref      = VREF_RESET;
    clear_window();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Single-group windows at the extremes, the threshold edge and each fault
    directed_rows.push_back(mk_row(0, 0, 0, 0, 4'h0, 1, 1, 0, 0, ST_STOPPED, FLT_NONE));
    directed_rows.push_back(mk_row(4095, 4095, 4095, 4095, 4'hF, 1, 1,
                                   4095, 3299, ST_RUNNING, FLT_NONE));
    directed_rows.push_back(mk_row(4095, 4095, 4095, 4095, 4'h0, 1, 1,
                                   4095, 3299, ST_FAULT, FLT_OVER));
    directed_rows.push_back(mk_row(0, 0, 0, 0, 4'hF, 1, 1, 0, 0, ST_FAULT, FLT_UNDER));
    directed_rows.push_back(mk_row(125, 125, 125, 125, 4'h0, 1, 1,
                                   125, 100, ST_STOPPED, FLT_NONE));
    directed_rows.push_back(mk_row(126, 126, 126, 126, 4'h0, 1, 1,
                                   126, 101, ST_FAULT, FLT_OVER));
    directed_rows.push_back(mk_row(125, 125, 125, 125, 4'hF, 1, 1,
                                   125, 100, ST_FAULT, FLT_UNDER));
    // Two groups: plain mean, mid-window word gives no report
    directed_rows.push_back(mk_row(12'hAAA, 12'h555, 0, 4095, 4'h5, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(12'h555, 12'hAAA, 4095, 0, 4'hA, 1, 0, 0, 0, 0, 0));
    // Three groups: smallest trimmed window
    directed_rows.push_back(mk_row(10, 4000, 2048, 7, 4'h3, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(500, 100, 2047, 4095, 4'h6, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(4095, 2500, 1, 300, 4'h9, 1, 0, 0, 0, 0, 0));
    // Five groups with a spike and a dropout on each channel
    directed_rows.push_back(mk_row(1000, 200, 3000, 150, 4'h1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1010, 4095, 2990, 160, 4'h2, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 210, 3010, 155, 4'h4, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(4095, 190, 0, 4095, 4'h8, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(990, 0, 4095, 0, 4'hC, 1, 0, 0, 0, 0, 0));

    foreach (directed_rows[i]) begin
      offer_group(directed_rows[i].grp);
      // Replace predicted values with the typed ones
      if (directed_rows[i].typed) begin
        n = motor_reports_due.size();
        for (int k = n - CHANNELS; k < n; k++) begin
          r = motor_reports_due[k];
          r.w.filtered   = directed_rows[i].filtered;
          r.w.milliamps  = directed_rows[i].milliamps;
          r.w.status     = directed_rows[i].status;
          r.w.fault      = directed_rows[i].fault;
          motor_reports_due[k] = r;
        end
      end
    end
    wait_reports_drained();

    // Random windows under a new configuration in each phase
    for (int phase = 1; phase < PHASES; phase++) begin
      case (phase)
        1: begin thr = 0;    vref = 5000; end
        2: begin thr = 5000; vref = 8191; end
        3: begin thr = 8191; vref = 0;    end
        4: begin thr = REG_W'($urandom_range(0, 5000)); vref = REG_W'($urandom); end
        default: begin thr = 0; vref = 8191; end
      endcase
      write_register(REG_THRESHOLD, thr);
      write_register(REG_VREF, vref);
      if (phase == 1) begin
        write_register(REG_SPARE0, REG_W'($urandom));
        write_register(REG_SPARE1, REG_W'($urandom));
      end
      cfg_we <= 1'b0;

      case (phase)
        1:       begin send_idle_pct <= 33; recv_idle_pct <= 81; end
        2, 3:    begin send_idle_pct <= 81; recv_idle_pct <= 33; end
        default: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
      endcase
      // Stall the results long enough to back up the input
      if (phase == 4) hold_epoch <= hold_epoch + 1;

      phase_items = 0;
      // Overlong window: the closing group itself is dropped
      if (phase == 1) begin
        send_window(MAX_WINDOW + 1);
        phase_items = MAX_WINDOW + 1;
      end

      while (phase_items < ITEMS_PER_PHASE) begin
        n = $urandom_range(99);
        if (n < 15)      len = 1;
        else if (n < 30) len = 2;
        else if (n < 45) len = 3;
        else             len = $urandom_range(4, 12);
        send_window(len);
        phase_items += len;
      end
      wait_reports_drained();
    end

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
